// File: design/sacu_pkg.sv
// Shared types and constants of the solute advection unit.
`default_nettype none
package sacu_pkg;

    localparam int WATER_W  = 31;
    localparam int DATA_W   = 32;
    localparam int FRAC_W   = 20;
    localparam int OPA_W    = 43;
    localparam int OPB_W    = 32;
    localparam int PROD_W   = 75;
    localparam int AQ_W     = 42;
    localparam int MAG_W    = 43;
    localparam int BOUND_W  = 42;
    localparam int FLUX_W   = 43;
    localparam int DIFF_W   = 44;
    localparam int STEP_W   = 41;
    localparam int SUM_W    = 43;
    localparam int CNT_W    = $clog2(PROD_W + 1);
    localparam int BOUND_DIV = 5;
    localparam logic [STEP_W-1:0] STEP_CAP = STEP_W'(1) << (STEP_W - 1);

    typedef enum logic [0:0] {
        OP_MUL,
        OP_DIV
    } sacu_op_t;

    typedef struct packed {
        logic     go;
        sacu_op_t op;
    } sacu_req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_AQ,
        S_FMUL,
        S_FDIV,
        S_BMUL,
        S_BDIV,
        S_FLUX,
        S_APPLY,
        S_EMIT
    } sacu_state_t;

endpackage
`default_nettype wire

// File: design/sacu_in_if.sv
// Input channel: one soil cell per transfer.
`default_nettype none
interface sacu_in_if;
    logic              valid;
    logic              ready;
    logic [30:0]       old_water;
    logic [30:0]       new_water;
    logic [30:0]       cell_width;
    logic signed [31:0] nitrate_in;
    logic signed [31:0] urea_in;
    logic              last_cell;

    modport source (output valid, old_water, new_water, cell_width, nitrate_in, urea_in,
                    last_cell, input ready);
    modport sink (input valid, old_water, new_water, cell_width, nitrate_in, urea_in,
                  last_cell, output ready);
endinterface
`default_nettype wire

// File: design/sacu_out_if.sv
// Output channel: one updated cell per transfer.
`default_nettype none
interface sacu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] nitrate_out;
    logic signed [31:0] urea_out;
    logic               last_out;

    modport source (output valid, nitrate_out, urea_out, last_out, input ready);
    modport sink (input valid, nitrate_out, urea_out, last_out, output ready);
endinterface
`default_nettype wire

// File: design/sacu_muldiv.sv
// Shared bit-serial multiplier and restoring divider, one bit per cycle.
`default_nettype none
module sacu_muldiv
    import sacu_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sacu_req_t         req,
    input  wire logic [PROD_W-1:0] opa,
    input  wire logic [OPB_W-1:0]  opb,
    output logic                   done,
    output logic [PROD_W-1:0]      result
);

    localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(OPB_W);
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(PROD_W);
    localparam int HI_W = PROD_W + 1 - OPB_W;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    sacu_op_t           op_reg, op_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [PROD_W:0]    work_reg, work_next;
    logic [OPA_W-1:0]   mcand_reg, mcand_next;
    logic [OPB_W-1:0]   dsr_reg, dsr_next;
    logic [OPB_W-1:0]   rem_reg, rem_next;

    logic [HI_W-1:0]    sum;
    logic [OPB_W:0]     trial;
    logic               ge;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg  <= work_next;
        mcand_reg <= mcand_next;
        dsr_reg   <= dsr_next;
        rem_reg   <= rem_next;
    end

    always_comb
    begin
        sum   = work_reg[PROD_W:OPB_W] + (work_reg[0] ? HI_W'(mcand_reg) : '0);
        trial = {rem_reg, work_reg[PROD_W-1]};
        ge    = trial >= {1'b0, dsr_reg};

        busy_next  = busy_reg;
        done_next  = 1'b0;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        work_next  = work_reg;
        mcand_next = mcand_reg;
        dsr_next   = dsr_reg;
        rem_next   = rem_reg;

        if (!busy_reg)
        begin
            if (req.go)
            begin
                busy_next = 1'b1;
                op_next   = req.op;
                dsr_next  = opb;
                rem_next  = '0;
                unique case (req.op)
                    OP_MUL:
                    begin
                        cnt_next   = MUL_STEPS;
                        work_next  = {{HI_W{1'b0}}, opb};
                        mcand_next = opa[OPA_W-1:0];
                    end
                    OP_DIV:
                    begin
                        cnt_next  = DIV_STEPS;
                        work_next = {1'b0, opa};
                    end
                    default:
                    begin
                        cnt_next = DIV_STEPS;
                    end
                endcase
            end
        end
        else
        begin
            unique case (op_reg)
                OP_MUL:
                begin
                    work_next = {1'b0, sum, work_reg[OPB_W-1:1]};
                end
                OP_DIV:
                begin
                    rem_next  = ge ? OPB_W'(trial - {1'b0, dsr_reg}) : trial[OPB_W-1:0];
                    work_next = {1'b0, work_reg[PROD_W-2:0], ge};
                end
                default:
                begin
                    work_next = work_reg;
                end
            endcase
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done   = done_reg;
    assign result = work_reg[PROD_W-1:0];

endmodule
`default_nettype wire

// File: design/solute_advection_between_cells_unit.sv
// Top level of the solute advection unit: cell sequencer around the shared arithmetic unit.
//
// Cells of one column arrive in order; the first is held unless it is final, each later one
// releases one result for the held cell, and a final cell behind a held one releases two
// (held cell, then itself), a lone final cell only its own. All arithmetic runs on one
// bit-serial multiply/divide unit, one operation at a time. A successor with zero old
// water skips the flux multiply and divide, and a zero width skips the update divide.
// One item is in work at a time; the input is ready only while the sequencer is idle.
`default_nettype none
module solute_advection_between_cells_unit
    import sacu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    sacu_in_if.sink   cell_in,
    sacu_out_if.source cell_out
);

    sacu_state_t state_reg, state_next;
    logic launched_reg, launched_next;
    logic sel_reg, sel_next;
    logic tail_reg, tail_next;
    logic pending_reg, pending_next;

    logic [WATER_W-1:0] h_ow_reg, h_nw_reg, h_w_reg, h_nit_reg, h_ur_reg;
    logic [WATER_W-1:0] n_ow_reg, n_nw_reg, n_w_reg, n_nit_reg, n_ur_reg;
    logic               n_last_reg;
    logic [AQ_W-1:0]    aq_reg, aq_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic [BOUND_W-1:0] bound_reg, bound_next;
    logic signed [FLUX_W-1:0] prior_n_reg, prior_n_next, prior_u_reg, prior_u_next;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic signed [DATA_W-1:0] out_n_reg, out_n_next, out_u_reg, out_u_next;

    logic capture, hold_load;
    sacu_req_t req;
    logic [PROD_W-1:0] opa;
    logic [OPB_W-1:0]  opb;
    logic              md_done;
    logic [PROD_W-1:0] md_res;

    logic neg;
    logic [WATER_W-1:0] dmag, c_h, c_n, ac, aw;
    logic signed [FLUX_W-1:0] prior_sel, flux;
    logic [BOUND_W-1:0] clamped;
    logic [DIFF_W-2:0]  diff_abs;
    logic [STEP_W-1:0]  step;
    logic signed [SUM_W-1:0] r;
    logic signed [DATA_W-1:0] r_sat;
    logic busy_state, go;

    sacu_muldiv u_md (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .opa    (opa),
        .opb    (opb),
        .done   (md_done),
        .result (md_res)
    );

    assign capture = cell_in.valid && cell_in.ready;
    assign cell_in.ready = state_reg == S_IDLE;
    assign cell_out.valid = state_reg == S_EMIT;
    assign cell_out.nitrate_out = out_n_reg;
    assign cell_out.urea_out = out_u_reg;
    assign cell_out.last_out = tail_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            launched_reg <= 1'b0;
            sel_reg      <= 1'b0;
            tail_reg     <= 1'b0;
            pending_reg  <= 1'b0;
            prior_n_reg  <= '0;
            prior_u_reg  <= '0;
            h_ow_reg     <= '0;
            h_nw_reg     <= '0;
            h_w_reg      <= '0;
            h_nit_reg    <= '0;
            h_ur_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
            sel_reg      <= sel_next;
            tail_reg     <= tail_next;
            pending_reg  <= pending_next;
            prior_n_reg  <= prior_n_next;
            prior_u_reg  <= prior_u_next;
            if (hold_load)
            begin
                h_ow_reg  <= n_ow_reg;
                h_nw_reg  <= n_nw_reg;
                h_w_reg   <= n_w_reg;
                h_nit_reg <= n_nit_reg;
                h_ur_reg  <= n_ur_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            n_ow_reg   <= cell_in.old_water;
            n_nw_reg   <= cell_in.new_water;
            n_w_reg    <= cell_in.cell_width;
            n_nit_reg  <= cell_in.nitrate_in[DATA_W-1] ? '0 : cell_in.nitrate_in[WATER_W-1:0];
            n_ur_reg   <= cell_in.urea_in[DATA_W-1] ? '0 : cell_in.urea_in[WATER_W-1:0];
            n_last_reg <= cell_in.last_cell;
        end
        aq_reg    <= aq_next;
        prod_reg  <= prod_next;
        mag_reg   <= mag_next;
        bound_reg <= bound_next;
        diff_reg  <= diff_next;
        out_n_reg <= out_n_next;
        out_u_reg <= out_u_next;
    end

    always_comb
    begin
        neg       = h_nw_reg < h_ow_reg;
        dmag      = neg ? h_ow_reg - h_nw_reg : h_nw_reg - h_ow_reg;
        c_h       = sel_reg ? h_ur_reg : h_nit_reg;
        c_n       = sel_reg ? n_ur_reg : n_nit_reg;
        ac        = tail_reg ? c_n : c_h;
        aw        = tail_reg ? n_w_reg : h_w_reg;
        prior_sel = sel_reg ? prior_u_reg : prior_n_reg;
        clamped   = (mag_reg > MAG_W'(bound_reg)) ? bound_reg : BOUND_W'(mag_reg);
        if (tail_reg)
            flux = '0;
        else if (neg)
            flux = -$signed({1'b0, clamped});
        else
            flux = $signed({1'b0, clamped});
        diff_abs = diff_reg[DIFF_W-1] ? (DIFF_W-1)'(-diff_reg) : diff_reg[DIFF_W-2:0];
        if (md_res > PROD_W'(STEP_CAP))
            step = STEP_CAP;
        else
            step = md_res[STEP_W-1:0];
        if (diff_reg[DIFF_W-1])
            r = $signed({{(SUM_W-WATER_W){1'b0}}, ac}) - $signed({{(SUM_W-STEP_W){1'b0}}, step});
        else
            r = $signed({{(SUM_W-WATER_W){1'b0}}, ac}) + $signed({{(SUM_W-STEP_W){1'b0}}, step});
        if (r > SUM_W'($signed({1'b0, {(DATA_W-1){1'b1}}})))
            r_sat = {1'b0, {(DATA_W-1){1'b1}}};
        else if (r < $signed({{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}}))
            r_sat = {1'b1, {(DATA_W-1){1'b0}}};
        else
            r_sat = r[DATA_W-1:0];
    end

    always_comb
    begin
        state_next    = state_reg;
        launched_next = launched_reg;
        sel_next      = sel_reg;
        tail_next     = tail_reg;
        pending_next  = pending_reg;
        prior_n_next  = prior_n_reg;
        prior_u_next  = prior_u_reg;
        aq_next       = aq_reg;
        prod_next     = prod_reg;
        mag_next      = mag_reg;
        bound_next    = bound_reg;
        diff_next     = diff_reg;
        out_n_next    = out_n_reg;
        out_u_next    = out_u_reg;
        hold_load     = 1'b0;
        busy_state    = 1'b0;
        opa           = '0;
        opb           = '0;
        req.op        = OP_MUL;

        unique case (state_reg)
            S_IDLE:
            begin
                if (capture)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                sel_next = 1'b0;
                if (pending_reg)
                begin
                    tail_next  = 1'b0;
                    state_next = S_AQ;
                end
                else if (n_last_reg)
                begin
                    tail_next  = 1'b1;
                    state_next = S_FLUX;
                end
                else
                begin
                    hold_load    = 1'b1;
                    pending_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_AQ:
            begin
                busy_state = 1'b1;
                opa = PROD_W'(dmag);
                opb = OPB_W'(h_w_reg);
                if (md_done)
                begin
                    aq_next  = md_res[FRAC_W +: AQ_W];
                    sel_next = 1'b0;
                    if (n_ow_reg == '0)
                    begin
                        mag_next   = '0;
                        state_next = S_BMUL;
                    end
                    else
                        state_next = S_FMUL;
                end
            end
            S_FMUL:
            begin
                busy_state = 1'b1;
                opa = PROD_W'(aq_reg);
                opb = OPB_W'(c_n);
                if (md_done)
                begin
                    prod_next  = md_res;
                    state_next = S_FDIV;
                end
            end
            S_FDIV:
            begin
                busy_state = 1'b1;
                req.op = OP_DIV;
                opa = prod_reg;
                opb = OPB_W'(n_ow_reg);
                if (md_done)
                begin
                    mag_next   = (md_res[PROD_W-1:MAG_W] != '0) ? '1 : md_res[MAG_W-1:0];
                    state_next = S_BMUL;
                end
            end
            S_BMUL:
            begin
                busy_state = 1'b1;
                opa = PROD_W'(neg ? c_h : c_n);
                opb = OPB_W'(neg ? h_w_reg : n_w_reg);
                if (md_done)
                begin
                    prod_next  = md_res;
                    state_next = S_BDIV;
                end
            end
            S_BDIV:
            begin
                busy_state = 1'b1;
                req.op = OP_DIV;
                opa = prod_reg >> FRAC_W;
                opb = OPB_W'(BOUND_DIV);
                if (md_done)
                begin
                    bound_next = md_res[BOUND_W-1:0];
                    state_next = S_FLUX;
                end
            end
            S_FLUX:
            begin
                diff_next = DIFF_W'(flux) - DIFF_W'(prior_sel);
                if (sel_reg)
                    prior_u_next = flux;
                else
                    prior_n_next = flux;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                busy_state = aw != '0;
                req.op = OP_DIV;
                opa = PROD_W'(diff_abs) << FRAC_W;
                opb = OPB_W'(aw);
                if (aw == '0 || md_done)
                begin
                    if (sel_reg)
                        out_u_next = (aw == '0) ? DATA_W'(ac) : r_sat;
                    else
                        out_n_next = (aw == '0) ? DATA_W'(ac) : r_sat;
                    if (!sel_reg)
                    begin
                        sel_next = 1'b1;
                        if (tail_reg)
                            state_next = S_FLUX;
                        else if (n_ow_reg == '0)
                        begin
                            mag_next   = '0;
                            state_next = S_BMUL;
                        end
                        else
                            state_next = S_FMUL;
                    end
                    else
                        state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (cell_out.ready)
                begin
                    if (tail_reg)
                    begin
                        pending_next = 1'b0;
                        tail_next    = 1'b0;
                        state_next   = S_IDLE;
                    end
                    else if (n_last_reg)
                    begin
                        tail_next  = 1'b1;
                        sel_next   = 1'b0;
                        state_next = S_FLUX;
                    end
                    else
                    begin
                        hold_load    = 1'b1;
                        pending_next = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        go = busy_state && !launched_reg && !md_done;
        req.go = go;
        if (md_done)
            launched_next = 1'b0;
        else if (go)
            launched_next = 1'b1;
    end

endmodule
`default_nettype wire

// File: sim/solute_advection_between_cells_unit_test.sv
// Testbench for the solute advection unit: cell columns in, predicted updated contents out.
module solute_advection_between_cells_unit_test;
    import sacu_pkg::*;

    typedef struct {
        logic [WATER_W-1:0]       old_water;
        logic [WATER_W-1:0]       new_water;
        logic [WATER_W-1:0]       cell_width;
        logic signed [DATA_W-1:0] nitrate;
        logic signed [DATA_W-1:0] urea;
        logic                     last_cell;
    } soil_cell_t;

    typedef struct {
        logic signed [DATA_W-1:0] nitrate;
        logic signed [DATA_W-1:0] urea;
        logic                     last_out;
    } updated_cell_t;

    logic clk;
    logic rst_n;
    sacu_in_if  cell_in ();
    sacu_out_if cell_out ();

    solute_advection_between_cells_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_in  (cell_in.sink),
        .cell_out (cell_out.source)
    );

    // predictor state: the held cell and the flux into the previous cell
    longint unsigned   kept_old_water, kept_new_water, kept_width, kept_nitrate, kept_urea;
    longint            prev_nitrate_flux, prev_urea_flux;
    bit                cell_held;

    updated_cell_t     awaited_cells[$];
    int                error_count;
    int                cells_sent;
    int                cells_checked;
    int                burst_left;
    bit                hold_request;
    bit                hold_active;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #300_000_000;
        $display("solute_advection_between_cells_unit_test NOT OK");
        $finish;
    end

    task automatic report(input string what, input longint got, input longint want);
        error_count++;
        $display("mismatch on result %0d: %s got %0d expected %0d", cells_checked, what, got,
                 want);
    endtask

    function automatic longint unsigned zeroed(input logic signed [DATA_W-1:0] c);
        return (c < 0) ? 64'd0 : longint'(c);
    endfunction

    function automatic longint flux_into(input longint unsigned ow, input longint unsigned nw,
                                         input longint unsigned w, input longint unsigned here,
                                         input longint unsigned next_ow,
                                         input longint unsigned next_w,
                                         input longint unsigned next_c);
        bit              drying;
        longint unsigned change, water_term, mag, lo, hi;
        logic [127:0]    quot;
        drying = nw < ow;
        change = drying ? ow - nw : nw - ow;
        water_term = (change * w) >> FRAC_W;
        mag = 0;
        if (next_ow != 0)
        begin
            quot = (128'(water_term) * 128'(next_c)) / 128'(next_ow);
            mag = (quot >= (128'(1) << 62)) ? (64'd1 << 62) : quot[63:0];
        end
        lo = ((here * w) / BOUND_DIV) >> FRAC_W;
        hi = ((next_c * next_w) / BOUND_DIV) >> FRAC_W;
        if (drying)
            return -longint'((mag > lo) ? lo : mag);
        return longint'((mag > hi) ? hi : mag);
    endfunction

    function automatic logic signed [DATA_W-1:0] updated(input longint unsigned c,
                                                         input longint unsigned w,
                                                         input longint flux,
                                                         input longint prev);
        longint          r, diff;
        longint unsigned mag, step;
        r = longint'(c);
        if (w != 0)
        begin
            diff = flux - prev;
            mag = (diff < 0) ? longint'(-diff) : longint'(diff);
            step = (mag << FRAC_W) / w;
            if (step > 64'(STEP_CAP))
                step = 64'(STEP_CAP);
            r = (diff < 0) ? r - longint'(step) : r + longint'(step);
        end
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[DATA_W-1:0];
    endfunction

    task automatic predict_cell(input soil_cell_t c);
        longint unsigned ow, nw, w, nit, ur;
        longint          fn, fu;
        updated_cell_t   res;
        ow = c.old_water;
        nw = c.new_water;
        w = c.cell_width;
        nit = zeroed(c.nitrate);
        ur = zeroed(c.urea);
        if (cell_held)
        begin
            fn = flux_into(kept_old_water, kept_new_water, kept_width, kept_nitrate, ow, w, nit);
            fu = flux_into(kept_old_water, kept_new_water, kept_width, kept_urea, ow, w, ur);
            res.nitrate = updated(kept_nitrate, kept_width, fn, prev_nitrate_flux);
            res.urea = updated(kept_urea, kept_width, fu, prev_urea_flux);
            res.last_out = 1'b0;
            awaited_cells.push_back(res);
            prev_nitrate_flux = fn;
            prev_urea_flux = fu;
        end
        if (c.last_cell)
        begin
            res.nitrate = updated(nit, w, 0, prev_nitrate_flux);
            res.urea = updated(ur, w, 0, prev_urea_flux);
            res.last_out = 1'b1;
            awaited_cells.push_back(res);
            prev_nitrate_flux = 0;
            prev_urea_flux = 0;
            cell_held = 1'b0;
        end
        else
        begin
            kept_old_water = ow;
            kept_new_water = nw;
            kept_width = w;
            kept_nitrate = nit;
            kept_urea = ur;
            cell_held = 1'b1;
        end
    endtask

    // sender: bursts of random length separated by random gaps
    task automatic send_cell(input soil_cell_t c);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            if ($urandom_range(0, 3) != 0)
                repeat (($urandom_range(0, 49) == 0) ? $urandom_range(100, 900)
                                                      : $urandom_range(1, 30))
                    @(negedge clk);
        end
        burst_left--;
        cell_in.old_water = c.old_water;
        cell_in.new_water = c.new_water;
        cell_in.cell_width = c.cell_width;
        cell_in.nitrate_in = c.nitrate;
        cell_in.urea_in = c.urea;
        cell_in.last_cell = c.last_cell;
        cell_in.valid = 1'b1;
        do
            @(posedge clk);
        while (!cell_in.ready);
        predict_cell(c);
        cells_sent++;
        @(negedge clk);
        cell_in.valid = 1'b0;
    endtask

    always @(posedge clk)
    begin
        updated_cell_t want;
        if (rst_n && cell_out.valid && cell_out.ready)
        begin
            if (awaited_cells.size() == 0)
            begin
                report("unexpected transfer", 0, 0);
            end
            else
            begin
                want = awaited_cells.pop_front();
                if (cell_out.nitrate_out !== want.nitrate)
                    report("nitrate_out", cell_out.nitrate_out, want.nitrate);
                if (cell_out.urea_out !== want.urea)
                    report("urea_out", cell_out.urea_out, want.urea);
                if (cell_out.last_out !== want.last_out)
                    report("last_out", cell_out.last_out, want.last_out);
            end
            cells_checked++;
        end
    end

    // receiver stall pattern, with a long hold-off on request
    initial begin
        int mode;
        int span;
        cell_out.ready = 1'b0;
        hold_active = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(16, 128);
            repeat (span)
            begin
                @(negedge clk);
                if (hold_request)
                begin
                    hold_active = 1'b1;
                    cell_out.ready = 1'b0;
                    repeat (3000)
                        @(negedge clk);
                    hold_request = 1'b0;
                    hold_active = 1'b0;
                end
                case (mode)
                    0: cell_out.ready = 1'b1;
                    1: cell_out.ready = $urandom_range(0, 1);
                    default: cell_out.ready = ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    function automatic logic [WATER_W-1:0] pick_water();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return WATER_W'($urandom);
            default: return WATER_W'($urandom_range(50_000, 600_000));
        endcase
    endfunction

    function automatic logic [WATER_W-1:0] pick_width();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return WATER_W'($urandom);
            4: return WATER_W'($urandom_range(1, 4096));
            default: return WATER_W'($urandom_range(1, 20)) << FRAC_W;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_content();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh8000_0000;
            3, 4: return DATA_W'($urandom);
            default: return DATA_W'($urandom_range(0, 200 << FRAC_W));
        endcase
    endfunction

    function automatic soil_cell_t random_cell(input logic last);
        soil_cell_t c;
        c.old_water = pick_water();
        c.new_water = ($urandom_range(0, 4) == 0) ? c.old_water : pick_water();
        c.cell_width = pick_width();
        c.nitrate = pick_content();
        c.urea = pick_content();
        c.last_cell = last;
        return c;
    endfunction

    function automatic soil_cell_t make_cell(input longint ow, input longint nw,
                                             input longint w, input longint nit,
                                             input longint ur, input logic last);
        soil_cell_t c;
        c.old_water = ow[WATER_W-1:0];
        c.new_water = nw[WATER_W-1:0];
        c.cell_width = w[WATER_W-1:0];
        c.nitrate = nit[DATA_W-1:0];
        c.urea = ur[DATA_W-1:0];
        c.last_cell = last;
        return c;
    endfunction

    task automatic send_column(input int depth);
        for (int i = 0; i < depth; i++)
            send_cell(random_cell(i == depth - 1));
    endtask

    task automatic test_column_shapes();
        send_cell(make_cell(300_000, 320_000, 5 << FRAC_W, 10 << FRAC_W, 3 << FRAC_W, 1));
        send_cell(make_cell(300_000, 250_000, 5 << FRAC_W, 10 << FRAC_W, 3 << FRAC_W, 0));
        send_cell(make_cell(350_000, 400_000, 5 << FRAC_W, 20 << FRAC_W, 1 << FRAC_W, 1));
        send_cell(make_cell(300_000, 400_000, 2 << FRAC_W, 1 << FRAC_W, 7 << FRAC_W, 0));
        send_cell(make_cell(200_000, 150_000, 3 << FRAC_W, 50 << FRAC_W, 2 << FRAC_W, 0));
        send_cell(make_cell(250_000, 250_000, 4 << FRAC_W, 5 << FRAC_W, 9 << FRAC_W, 0));
        send_cell(make_cell(260_000, 280_000, 4 << FRAC_W, 8 << FRAC_W, 4 << FRAC_W, 1));
    endtask

    task automatic test_zero_and_negative();
        // successor with zero old water, then a zero-width cell, then negative contents
        send_cell(make_cell(300_000, 500_000, 5 << FRAC_W, 10 << FRAC_W, 10 << FRAC_W, 0));
        send_cell(make_cell(0, 400_000, 5 << FRAC_W, 30 << FRAC_W, 30 << FRAC_W, 0));
        send_cell(make_cell(300_000, 100_000, 0, 12 << FRAC_W, 6 << FRAC_W, 0));
        send_cell(make_cell(300_000, 200_000, 3 << FRAC_W, -1, 32'sh8000_0000, 0));
        send_cell(make_cell(200_000, 300_000, 3 << FRAC_W, -5 << FRAC_W, 4 << FRAC_W, 1));
        send_cell(make_cell(0, 0, 0, -7, -9, 1));
    endtask

    task automatic test_extremes();
        send_cell(make_cell(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0));
        send_cell(make_cell(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0));
        send_cell(make_cell(0, 32'h7FFF_FFFF, 1, 32'sh7FFF_FFFF, 0, 0));
        send_cell(make_cell(1, 0, 32'h7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0));
        send_cell(make_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0, 32'sh7FFF_FFFF, 1));
        send_cell(make_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'sh7FFF_FFFF,
                            32'sh7FFF_FFFF, 1));
    endtask

    task automatic test_backpressure();
        hold_request = 1'b1;
        wait (hold_active);
        send_column(6);
    endtask

    task automatic test_random_columns();
        int depth;
        while (cells_sent < 1100)
        begin
            if ($urandom_range(0, 9) == 0)
                depth = 1;
            else
                depth = $urandom_range(2, 7);
            send_column(depth);
        end
    endtask

    initial begin
        int waited;
        rst_n = 1'b0;
        cell_in.valid = 1'b0;
        cell_in.old_water = '0;
        cell_in.new_water = '0;
        cell_in.cell_width = '0;
        cell_in.nitrate_in = '0;
        cell_in.urea_in = '0;
        cell_in.last_cell = 1'b0;
        hold_request = 1'b0;
        error_count = 0;
        cells_sent = 0;
        cells_checked = 0;
        burst_left = 0;
        kept_old_water = 0;
        kept_new_water = 0;
        kept_width = 0;
        kept_nitrate = 0;
        kept_urea = 0;
        prev_nitrate_flux = 0;
        prev_urea_flux = 0;
        cell_held = 1'b0;
        repeat (8)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_column_shapes();
        test_zero_and_negative();
        test_extremes();
        test_backpressure();
        test_random_columns();

        waited = 0;
        while (awaited_cells.size() != 0 && waited < 200_000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (1000)
            @(posedge clk);
        if (awaited_cells.size() != 0)
            report("results never delivered", awaited_cells.size(), 0);

        $display("cells sent: %0d, updated cells checked: %0d, mismatches: %0d",
                 cells_sent, cells_checked, error_count);
        $display("covered lone and paired final cells, zero divisors and widths, negative and");
        $display("extreme contents, and a long output stall that backs up the input");
        if (error_count == 0)
            $display("solute_advection_between_cells_unit_test OK");
        else
            $display("solute_advection_between_cells_unit_test NOT OK");
        $finish;
    end

endmodule
